@@ src/she_pkg.sv @@
// ----------------------------------------------------------------------------
// she_pkg
// Shared types, constants and round functions of the sha-256 hash engine.
// ----------------------------------------------------------------------------
`default_nettype none

package she_pkg;

	// initial hash value, word 0 in slot 0
	localparam logic [7:0][31:0] INIT_HASH = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [5:0] LAST_ROUND  = 6'd63;
	localparam logic [5:0] LAST_POS    = 6'd63;
	localparam logic [5:0] LENGTH_POS  = 6'd56;
	localparam logic [2:0] LAST_WORD   = 3'd7;
	localparam logic [7:0] PAD_MARK    = 8'h80;

	// source of the byte written into the block buffer
	typedef enum logic [1:0] {
		SRC_INPUT,
		SRC_MARK,
		SRC_ZERO,
		SRC_LENGTH
	} byte_src_t;

	// controller to datapath
	typedef struct packed {
		logic       put_byte;
		byte_src_t  src;
		logic       add_length;
		logic       load_work;
		logic       round;
		logic [5:0] round_idx;
		logic       fold;
		logic       restart;
		logic [2:0] word_idx;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pos_last;
		logic at_length;
	} dp_stat_t;

	function automatic logic [31:0] small_sig0(input logic [31:0] v);
		return {v[6:0], v[31:7]} ^ {v[17:0], v[31:18]} ^ {3'b000, v[31:3]};
	endfunction

	function automatic logic [31:0] small_sig1(input logic [31:0] v);
		return {v[16:0], v[31:17]} ^ {v[18:0], v[31:19]} ^ {10'd0, v[31:10]};
	endfunction

	function automatic logic [31:0] big_sig0(input logic [31:0] v);
		return {v[1:0], v[31:2]} ^ {v[12:0], v[31:13]} ^ {v[21:0], v[31:22]};
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] v);
		return {v[5:0], v[31:6]} ^ {v[10:0], v[31:11]} ^ {v[24:0], v[31:25]};
	endfunction

	// round constants
	function automatic logic [31:0] round_const(input logic [5:0] idx);
		logic [31:0] k;
		unique case (idx)
			6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
			default: k = 32'h00000000;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

@@ src/she_datapath.sv @@
// ----------------------------------------------------------------------------
// she_datapath
// Block buffer / message schedule, round unit, chaining hash and counters.
// ----------------------------------------------------------------------------
`default_nettype none

module she_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire she_pkg::dp_cmd_t  cmd,
	input  wire logic [7:0]        data_byte,
	output      she_pkg::dp_stat_t stat,
	output      logic [31:0]       digest_word
);

	localparam logic [5:0] LEN_TOP = 6'd56;

	logic [7:0][31:0]  chain_q;
	logic [7:0][31:0]  work_q;
	logic [15:0][31:0] win_q;
	logic [63:0]       bit_length_q;
	logic [5:0]        pos_q;

	logic [7:0]  byte_val;
	logic [5:0]  len_shift;
	logic [31:0] ch, maj, t1, t2, w_next;

	// byte to place in the block
	assign len_shift = LEN_TOP - {pos_q[2:0], 3'b000};
	always_comb begin
		unique case (cmd.src)
			she_pkg::SRC_INPUT:  byte_val = data_byte;
			she_pkg::SRC_MARK:   byte_val = she_pkg::PAD_MARK;
			she_pkg::SRC_ZERO:   byte_val = 8'h00;
			she_pkg::SRC_LENGTH: byte_val = bit_length_q[len_shift +: 8];
			default:             byte_val = 8'h00;
		endcase
	end

	// one compression round
	assign ch  = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
	assign maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
	assign t1  = work_q[7] + she_pkg::big_sig1(work_q[4]) + ch
		+ she_pkg::round_const(cmd.round_idx) + win_q[0];
	assign t2  = she_pkg::big_sig0(work_q[0]) + maj;

	// schedule expansion, word sixteen rounds ahead
	assign w_next = she_pkg::small_sig1(win_q[14]) + win_q[9]
		+ she_pkg::small_sig0(win_q[1]) + win_q[0];

	// block buffer and schedule window
	always_ff @(posedge clk) begin
		if (cmd.put_byte) begin
			unique case (pos_q[1:0])
				2'd0: win_q[pos_q[5:2]] <= {byte_val, 24'd0};
				2'd1: win_q[pos_q[5:2]][23:16] <= byte_val;
				2'd2: win_q[pos_q[5:2]][15:8] <= byte_val;
				2'd3: win_q[pos_q[5:2]][7:0] <= byte_val;
				default: win_q[pos_q[5:2]] <= {byte_val, 24'd0};
			endcase
		end else if (cmd.round) begin
			win_q <= {w_next, win_q[15:1]};
		end
	end

	// working variables a..h
	always_ff @(posedge clk) begin
		if (cmd.load_work) begin
			work_q <= chain_q;
		end else if (cmd.round) begin
			work_q <= {work_q[6:4], work_q[3] + t1, work_q[2:0], t1 + t2};
		end
	end

	// chaining hash, length and byte position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q      <= she_pkg::INIT_HASH;
			bit_length_q <= 64'd0;
			pos_q        <= 6'd0;
		end else begin
			if (cmd.restart) begin
				chain_q      <= she_pkg::INIT_HASH;
				bit_length_q <= 64'd0;
				pos_q        <= 6'd0;
			end else begin
				if (cmd.fold) begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + work_q[i];
					end
				end
				if (cmd.add_length) begin
					bit_length_q <= bit_length_q + 64'd8;
				end
				if (cmd.put_byte) begin
					pos_q <= pos_q + 6'd1;
				end
			end
		end
	end

	assign stat.pos_last  = (pos_q == she_pkg::LAST_POS);
	assign stat.at_length = (pos_q == she_pkg::LENGTH_POS);
	assign digest_word    = chain_q[cmd.word_idx];

endmodule

`default_nettype wire

@@ src/she_ctrl.sv @@
// ----------------------------------------------------------------------------
// she_ctrl
// Sequencer: byte intake, padding, compression rounds and digest readout.
// ----------------------------------------------------------------------------
`default_nettype none

module she_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              has_byte,
	input  wire logic              end_of_message,
	input  wire logic              out_stall,
	input  wire she_pkg::dp_stat_t stat,
	output      she_pkg::dp_cmd_t  cmd,
	output      logic              in_stall,
	output      logic              out_valid,
	output      logic [2:0]        word_number,
	output      logic              last_word
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD_MARK,
		ST_PAD_ZERO,
		ST_PAD_LEN,
		ST_ROUNDS,
		ST_FOLD,
		ST_OUTPUT
	} state_t;

	state_t     state_q, state_d;
	state_t     ret_q, ret_d;
	logic [5:0] rnd_q;
	logic [2:0] word_q;
	logic       accept;

	assign accept = in_valid && (state_q == ST_IDLE);

	// command decode and next state
	always_comb begin
		cmd           = '0;
		cmd.src       = she_pkg::SRC_INPUT;
		cmd.round_idx = rnd_q;
		cmd.word_idx  = word_q;
		state_d       = state_q;
		ret_d         = ret_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (has_byte) begin
						cmd.put_byte   = 1'b1;
						cmd.add_length = 1'b1;
					end
					if (has_byte && stat.pos_last) begin
						cmd.load_work = 1'b1;
						state_d       = ST_ROUNDS;
						ret_d         = end_of_message ? ST_PAD_MARK : ST_IDLE;
					end else if (end_of_message) begin
						state_d = ST_PAD_MARK;
					end
				end
			end
			ST_PAD_MARK: begin
				cmd.put_byte = 1'b1;
				cmd.src      = she_pkg::SRC_MARK;
				if (stat.pos_last) begin
					cmd.load_work = 1'b1;
					state_d       = ST_ROUNDS;
					ret_d         = ST_PAD_ZERO;
				end else begin
					state_d = ST_PAD_ZERO;
				end
			end
			ST_PAD_ZERO: begin
				if (stat.at_length) begin
					state_d = ST_PAD_LEN;
				end else begin
					cmd.put_byte = 1'b1;
					cmd.src      = she_pkg::SRC_ZERO;
					if (stat.pos_last) begin
						cmd.load_work = 1'b1;
						state_d       = ST_ROUNDS;
						ret_d         = ST_PAD_ZERO;
					end
				end
			end
			ST_PAD_LEN: begin
				cmd.put_byte = 1'b1;
				cmd.src      = she_pkg::SRC_LENGTH;
				if (stat.pos_last) begin
					cmd.load_work = 1'b1;
					state_d       = ST_ROUNDS;
					ret_d         = ST_OUTPUT;
				end
			end
			ST_ROUNDS: begin
				cmd.round = 1'b1;
				if (rnd_q == she_pkg::LAST_ROUND) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				state_d  = ret_q;
			end
			ST_OUTPUT: begin
				if (!out_stall && word_q == she_pkg::LAST_WORD) begin
					cmd.restart = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state, round counter and word counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			rnd_q   <= 6'd0;
			word_q  <= 3'd0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (state_q == ST_ROUNDS) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (state_q == ST_OUTPUT && !out_stall) begin
				word_q <= word_q + 3'd1;
			end
		end
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = (state_q == ST_OUTPUT);
	assign word_number = word_q;
	assign last_word   = (word_q == she_pkg::LAST_WORD);

endmodule

`default_nettype wire

@@ src/sha256_hash_engine.sv @@
// ----------------------------------------------------------------------------
// sha256_hash_engine
// Byte-serial sha-256: absorbs a message one byte per item, pads it and
// returns the 256-bit digest as eight 32-bit words.
// ----------------------------------------------------------------------------
// A message byte is taken only while the sequencer is idle. Every 64th byte
// starts a compression on the single round unit: the working variables load
// in the cycle that takes that byte, then the rounds run and the result is
// folded into the chaining hash; no new byte is taken until the fold is done.
// An end item adds one padding or length byte per cycle outside compressions
// (9 to 72 bytes), passes the length position without writing a byte, runs
// one or two compressions, then gives eight digest words, one per cycle
// while out_stall is low. No item is taken from the end of message until
// the last digest word leaves; the engine then restarts from the initial
// hash value.
`default_nettype none

module sha256_hash_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        has_byte,
	input  wire logic        end_of_message,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [31:0] digest_word,
	output      logic [2:0]  word_number,
	output      logic        last_word
);

	she_pkg::dp_cmd_t  cmd;
	she_pkg::dp_stat_t stat;

	// sequencer
	she_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.has_byte       (has_byte),
		.end_of_message (end_of_message),
		.out_stall      (out_stall),
		.stat           (stat),
		.cmd            (cmd),
		.in_stall       (in_stall),
		.out_valid      (out_valid),
		.word_number    (word_number),
		.last_word      (last_word)
	);

	// hash datapath
	she_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.stat        (stat),
		.digest_word (digest_word)
	);

endmodule

`default_nettype wire

@@ verif/sha256_hash_engine_tb.sv @@
// ----------------------------------------------------------------------------
// sha256_hash_engine_tb
// Self-checking bench for the byte-serial sha-256 engine. Messages are fed
// one byte per item, and every item taken is run through a local digest
// model. Each digest word that leaves the engine is compared with the oldest
// predicted word. Sender gaps and receiver stalls change from phase to phase,
// and one long output hold makes the engine back up its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module sha256_hash_engine_tb;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 200;
	localparam int HOLD_CYCLES  = 600;
	localparam int MAX_REPORTS  = 10;

	localparam logic [7:0] PAD_BYTE      = 8'h80;
	localparam logic [5:0] LEN_FIELD_POS = 6'd56;
	localparam logic [2:0] FINAL_WORD    = 3'd7;

	localparam logic [31:0] HASH_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       eom;
	} byte_item_t;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  word_idx;
		logic        last;
	} digest_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        has_byte = 1'b0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_number;
	logic        last_word;

	byte_item_t  pending_items [$];
	digest_t     digest_expect [$];
	byte_item_t  next_item;
	digest_t     want;

	int sender_idle_pct = 0;
	int recv_stall_pct  = 0;
	int stall_hold      = 0;
	int cycle_count     = 0;
	int error_count     = 0;
	bit in_taken        = 1'b0;

	// local copy of the engine state
	logic [31:0] hash_state [8];
	logic [31:0] block_words [16];
	logic [63:0] msg_bits;
	logic [5:0]  byte_pos;

	sha256_hash_engine dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.has_byte       (has_byte),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.digest_word    (digest_word),
		.word_number    (word_number),
		.last_word      (last_word)
	);

	// round helpers
	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	function automatic logic [31:0] lower_sigma0(input logic [31:0] v);
		return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
	endfunction

	function automatic logic [31:0] lower_sigma1(input logic [31:0] v);
		return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
	endfunction

	function automatic logic [31:0] upper_sigma0(input logic [31:0] v);
		return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
	endfunction

	function automatic logic [31:0] upper_sigma1(input logic [31:0] v);
		return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
	endfunction

	// one 64-round compression of the block buffer into the chaining hash
	task automatic compress_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2, ch, mj;
		for (int i = 0; i < 16; i++)
			w[i] = block_words[i];
		for (int i = 16; i < 64; i++)
			w[i] = lower_sigma1(w[i-2]) + w[i-7] + lower_sigma0(w[i-15]) + w[i-16];
		for (int i = 0; i < 8; i++)
			v[i] = hash_state[i];
		for (int i = 0; i < 64; i++) begin
			ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
			mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
			t1 = v[7] + upper_sigma1(v[4]) + ch + ROUND_K[i] + w[i];
			t2 = upper_sigma0(v[0]) + mj;
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_state[i] = hash_state[i] + v[i];
	endtask

	// big-endian packing, compress on every 64th byte
	task automatic absorb_byte(input logic [7:0] b);
		logic [4:0] shift;
		shift = 5'((3 - byte_pos[1:0]) * 8);
		if (byte_pos[1:0] == 2'd0) begin
			block_words[byte_pos[5:2]] = {b, 24'h000000};
		end else begin
			block_words[byte_pos[5:2]] = block_words[byte_pos[5:2]] | ({24'h0, b} << shift);
		end
		byte_pos = byte_pos + 6'd1;
		if (byte_pos == 6'd0)
			compress_block();
	endtask

	task automatic restart_hash();
		for (int i = 0; i < 8; i++)
			hash_state[i] = HASH_IV[i];
		msg_bits = 64'd0;
		byte_pos = 6'd0;
	endtask

	// expected digest words caused by one accepted item
	task automatic predict_digest(input logic [7:0] d, input logic has, input logic eom);
		logic [63:0] len;
		digest_t     e;
		if (has) begin
			absorb_byte(d);
			msg_bits = msg_bits + 64'd8;
		end
		if (eom) begin
			len = msg_bits;
			absorb_byte(PAD_BYTE);
			while (byte_pos != LEN_FIELD_POS)
				absorb_byte(8'h00);
			for (int i = 0; i < 8; i++)
				absorb_byte(8'(len >> (56 - 8 * i)));
			for (int i = 0; i < 8; i++) begin
				e.word     = hash_state[i];
				e.word_idx = 3'(i);
				e.last     = (3'(i) == FINAL_WORD);
				digest_expect.push_back(e);
			end
			restart_hash();
		end
	endtask

	// message of len random bytes, ended on the last byte or by a bare marker
	task automatic queue_message(input int len, inout int count);
		byte_item_t it;
		bit         bare_end;
		bare_end = (len == 0) || ($urandom_range(1) == 1);
		for (int i = 0; i < len; i++) begin
			// ignored item slipped in now and then
			if ($urandom_range(99) < 6) begin
				it.data = 8'($urandom);
				it.has  = 1'b0;
				it.eom  = 1'b0;
				pending_items.push_back(it);
			end
			it.data = 8'($urandom);
			it.has  = 1'b1;
			it.eom  = (i == len - 1) && !bare_end;
			pending_items.push_back(it);
			count++;
		end
		if (bare_end) begin
			it.data = 8'($urandom);
			it.has  = 1'b0;
			it.eom  = 1'b1;
			pending_items.push_back(it);
			count++;
		end
	endtask

	task automatic queue_raw(input logic [7:0] d, input logic has, input logic eom);
		byte_item_t it;
		it.data = d;
		it.has  = has;
		it.eom  = eom;
		pending_items.push_back(it);
	endtask

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// input driver: new item at the falling edge once the last one was taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				next_item = pending_items.pop_front();
				in_valid       <= 1'b1;
				data_byte      <= next_item.data;
				has_byte       <= next_item.has;
				end_of_message <= next_item.eom;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output stall: long hold when requested, random otherwise
	always @(negedge clk) begin
		if (stall_hold > 0) begin
			out_stall <= 1'b1;
			stall_hold = stall_hold - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// monitor: predict on taken items, check each digest word
	always @(posedge clk) begin
		cycle_count++;
		in_taken = arst_n && in_valid && !in_stall;
		if (in_taken)
			predict_digest(data_byte, has_byte, end_of_message);
		if (arst_n && out_valid && !out_stall) begin
			if (digest_expect.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("unexpected digest word %h num %0d last %b",
						digest_word, word_number, last_word);
			end else begin
				want = digest_expect.pop_front();
				if (digest_word !== want.word || word_number !== want.word_idx ||
						last_word !== want.last) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("digest mismatch: exp %h num %0d last %b, got %h num %0d last %b",
							want.word, want.word_idx, want.last,
							digest_word, word_number, last_word);
				end
			end
		end
	end

	// run limit
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// stimulus
	initial begin
		int items;
		int msgs;
		int len;
		int r;
		int forced;
		restart_hash();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: ignored item, empty message, byte extremes, short messages
		queue_raw(8'hff, 1'b0, 1'b0);
		queue_raw(8'h00, 1'b0, 1'b1);
		queue_raw(8'h00, 1'b1, 1'b1);
		queue_raw(8'hff, 1'b1, 1'b1);
		queue_raw(8'h61, 1'b1, 1'b0);
		queue_raw(8'h62, 1'b1, 1'b0);
		queue_raw(8'h63, 1'b1, 1'b1);
		queue_raw(8'h5a, 1'b1, 1'b0);
		queue_raw(8'ha5, 1'b0, 1'b0);
		queue_raw(8'hc3, 1'b1, 1'b0);
		queue_raw(8'h3c, 1'b0, 1'b1);
		while (pending_items.size() != 0)
			@(posedge clk);

		// random messages over the idling phases
		forced = 0;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin sender_idle_pct = 57; recv_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  recv_stall_pct = 57; end
				default: begin sender_idle_pct = 7; recv_stall_pct = 7; end
			endcase
			items = 0;
			msgs  = 0;
			while (items < 16 || msgs < 1) begin
				// padding spill and exact block first, then mostly short ones
				if (forced == 0) begin
					len = 60;
				end else if (forced == 1) begin
					len = 64;
				end else begin
					r = $urandom_range(99);
					if (r < 60)
						len = $urandom_range(16, 0);
					else if (r < 90)
						len = $urandom_range(68, 52);
					else
						len = $urandom_range(130, 100);
				end
				forced++;
				queue_message(len, items);
				msgs++;
			end
			// output held off while the sender keeps going
			if (ph == 0)
				stall_hold = HOLD_CYCLES;
			while (pending_items.size() != 0)
				@(posedge clk);
		end

		// drain
		while (pending_items.size() != 0 || in_valid)
			@(posedge clk);
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		while (digest_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire

@@ sha256_hash_engine.f @@
src/she_pkg.sv
src/she_datapath.sv
src/she_ctrl.sv
src/sha256_hash_engine.sv
verif/sha256_hash_engine_tb.sv
